FILE: hdl/set_assoc_cache_tag_lru_unit_assert.svh
// Assertion macros shared by the cache tag and replacement unit.
`ifndef SET_ASSOC_CACHE_TAG_LRU_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LRU_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SACTL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define SACTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sactl_pkg.sv
// Shared constants and types of the cache tag and replacement unit.
`timescale 1ns / 1ps
package sactl_pkg;

  localparam int unsigned SETS_DEF          = 64;
  localparam int unsigned WAYS_DEF          = 4;
  localparam int unsigned LINE_BYTES_DEF    = 64;
  localparam int unsigned ADDR_BITS_DEF     = 32;
  localparam int unsigned BYPASS_RANGES_DEF = 2;

  // Use stamps and the use tick are fixed at 32 bits.
  localparam int unsigned STAMP_W = 32;

  // Register index: bit 0 picks the bound, the upper bits pick the range.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic RANGE_BOUND_START = 1'b0;
  localparam logic RANGE_BOUND_END   = 1'b1;

  // Decision of one lookup, handed from the tag compare to the top level.
  typedef struct packed {
    logic hit;
    logic fill;
    logic forward;
    logic update;
  } lk_status_t;

endpackage

FILE: hdl/set_assoc_cache_tag_lru_unit.sv
// Top level of the set-associative cache tag directory with LRU replacement.
`timescale 1ns / 1ps
//
//   channel  direction  handshake               payload
//   in_      slave      in_tvalid / in_tready   tuser = kind, tdata = address
//   out_     master     out_tvalid / out_tready tdata = lookup result
//   cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// A beat is registered and its set's tag and stamp rows are read on the
// accepting edge; the output register is loaded when the lookup stage moves
// on, and a beat can be taken every cycle while the output is not stalled.
// A same-set beat right behind an update gets the new rows by forwarding.
// Reset clears the valid flip-flops at once (no clearing pass) and the ranges.
// A stalled output holds the lookup stage; input waits only while it is held.
`include "set_assoc_cache_tag_lru_unit_assert.svh"
module set_assoc_cache_tag_lru_unit #(
  parameter int unsigned SETS          = sactl_pkg::SETS_DEF,
  parameter int unsigned WAYS          = sactl_pkg::WAYS_DEF,
  parameter int unsigned LINE_BYTES    = sactl_pkg::LINE_BYTES_DEF,
  parameter int unsigned ADDR_BITS     = sactl_pkg::ADDR_BITS_DEF,
  parameter int unsigned BYPASS_RANGES = sactl_pkg::BYPASS_RANGES_DEF,
  localparam int unsigned OFF_W        = $clog2(LINE_BYTES),
  localparam int unsigned WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int unsigned IN_TDATA_W   = ((ADDR_BITS + 7) / 8) * 8,
  localparam int unsigned RES_W        = 4 + WAY_W + ADDR_BITS + OFF_W,
  localparam int unsigned OUT_TDATA_W  = ((RES_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Access channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,   // address
  input  logic                            in_tuser,   // kind: 0 read, 1 write
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // bypass, hit, way, fill_request, forward, line_address, byte_offset
  output logic [OUT_TDATA_W-1:0]          out_tdata,
  // Register write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sactl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_BITS-1:0]            cfg_wdata
);
  import sactl_pkg::*;

  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned TAG_W    = ADDR_BITS - OFF_W - SET_BITS;

  // Handshakes.
  logic in_acc;
  logic s1_adv;

  // Lookup stage: the accepted beat, waiting on its RAM rows.
  logic                 s1_valid_r;
  logic                 s1_kind_r;
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic [SET_W-1:0]     s1_set;
  logic [TAG_W-1:0]     s1_tag;
  logic                 s1_byp;

  logic [ADDR_BITS-1:0] in_addr;
  logic [SET_W-1:0]     in_set;

  // Directory state.
  logic [WAYS-1:0]         valid_r [SETS];
  logic [STAMP_W-1:0]      tick_r;
  logic [STAMP_W-1:0]      tick_nxt;
  logic [WAYS*TAG_W-1:0]   tag_q;
  logic [WAYS*STAMP_W-1:0] stamp_q;

  // Same-set forwarding of the row written while the next beat read it.
  logic                    fwd_hit_r;
  logic [WAYS*TAG_W-1:0]   fwd_tag_r;
  logic [WAYS*STAMP_W-1:0] fwd_stamp_r;
  logic [WAYS*TAG_W-1:0]   tag_row;
  logic [WAYS*STAMP_W-1:0] stamp_row;

  // Lookup outcome.
  lk_status_t              lk_st;
  logic [WAY_W-1:0]        lk_way;
  logic [WAYS*TAG_W-1:0]   tag_row_nxt;
  logic [WAYS*STAMP_W-1:0] stamp_row_nxt;
  logic                    ram_wr_en;

  // Output register.
  logic                 out_valid_r;
  logic [RES_W-1:0]     res;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [ADDR_BITS-1:0] line_base;

  assign cfg_ready = 1'b1;

  assign in_addr = in_tdata[ADDR_BITS-1:0];
  assign in_set  = (SET_BITS == 0) ? '0 : in_addr[OFF_W +: SET_W];
  assign s1_set  = (SET_BITS == 0) ? '0 : s1_addr_r[OFF_W +: SET_W];
  assign s1_tag  = s1_addr_r[ADDR_BITS-1 -: TAG_W];

  // The stage moves when the output register is empty or being drained.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_tuser;
      s1_addr_r <= in_addr;
    end
  end

  sactl_bypass_regs #(
    .RANGES    (BYPASS_RANGES),
    .ADDR_BITS (ADDR_BITS)
  ) u_bypass (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .addr     (s1_addr_r),
    .in_range (s1_byp)
  );

  // Both rows are rewritten whole on every hit or fill.
  assign ram_wr_en = s1_adv && lk_st.update;

  sactl_ram #(
    .WIDTH (WAYS * TAG_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (s1_set),
    .wr_data (tag_row_nxt),
    .rd_en   (in_acc),
    .rd_addr (in_set),
    .rd_data (tag_q)
  );

  sactl_ram #(
    .WIDTH (WAYS * STAMP_W),
    .DEPTH (SETS)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (s1_set),
    .wr_data (stamp_row_nxt),
    .rd_en   (in_acc),
    .rd_addr (in_set),
    .rd_data (stamp_q)
  );

  // The RAMs return the old row when a beat reads the set that the beat
  // ahead of it writes in the same cycle, so that row is kept here instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_acc) begin
      fwd_hit_r <= ram_wr_en && (s1_set == in_set);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_tag_r   <= tag_row_nxt;
      fwd_stamp_r <= stamp_row_nxt;
    end
  end

  assign tag_row   = fwd_hit_r ? fwd_tag_r : tag_q;
  assign stamp_row = fwd_hit_r ? fwd_stamp_r : stamp_q;

  // Every cached beat advances the tick; its new value is the fresh stamp.
  assign tick_nxt = tick_r + STAMP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (s1_adv && !s1_byp) begin
      tick_r <= tick_nxt;
    end
  end

  sactl_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .WAY_W (WAY_W)
  ) u_lookup (
    .kind          (s1_kind_r),
    .in_range      (s1_byp),
    .tag           (s1_tag),
    .valid_row     (valid_r[s1_set]),
    .tag_row       (tag_row),
    .stamp_row     (stamp_row),
    .new_stamp     (tick_nxt),
    .status        (lk_st),
    .way           (lk_way),
    .tag_row_nxt   (tag_row_nxt),
    .stamp_row_nxt (stamp_row_nxt)
  );

  // A read miss marks its victim valid right away; writes never allocate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else if (s1_adv && lk_st.fill) begin
      valid_r[s1_set][lk_way] <= 1'b1;
    end
  end

  assign line_base = {s1_addr_r[ADDR_BITS-1:OFF_W], {OFF_W{1'b0}}};
  assign res = {s1_addr_r[OFF_W-1:0], line_base, lk_st.forward, lk_st.fill,
                lk_way, lk_st.hit, s1_byp};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= OUT_TDATA_W'(res);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SACTL_ASSERT_SAME(a_fill_read_miss, s1_adv && lk_st.fill,
                     !s1_byp && !lk_st.hit && !s1_kind_r, "fill outside a cached read miss")
  `SACTL_ASSERT_SAME(a_bypass_untouched, s1_adv && s1_byp,
                     lk_st.forward && !ram_wr_en, "bypassed beat touched the directory")
  `SACTL_ASSERT_SAME(a_write_miss_quiet, s1_adv && s1_kind_r && !lk_st.hit,
                     !ram_wr_en && lk_st.forward, "write miss allocated")
  `SACTL_ASSERT_NEXT(a_tick_hold, !(s1_adv && !s1_byp),
                     $stable(tick_r), "tick moved without a cached beat")

endmodule

FILE: hdl/sactl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module sactl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/sactl_bypass_regs.sv
// Uncached range registers and the range check of one address.
`timescale 1ns / 1ps
module sactl_bypass_regs #(
  parameter int unsigned RANGES    = sactl_pkg::BYPASS_RANGES_DEF,
  parameter int unsigned ADDR_BITS = sactl_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [sactl_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ADDR_BITS-1:0]           wr_data,
  input  logic [ADDR_BITS-1:0]           addr,
  output logic                           in_range
);
  import sactl_pkg::*;

  logic [ADDR_BITS-1:0] lo_r [RANGES];
  logic [ADDR_BITS-1:0] hi_r [RANGES];
  logic [RANGES-1:0]    range_match;

  // An index past the last range matches no pair and is dropped.
  for (genvar r = 0; r < RANGES; r++) begin : g_range
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lo_r[r] <= '1;
        hi_r[r] <= '0;
      end else if (wr_en && wr_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(r)) begin
        if (wr_index[0] == RANGE_BOUND_END) begin
          hi_r[r] <= wr_data;
        end else if (wr_index[0] == RANGE_BOUND_START) begin
          lo_r[r] <= wr_data;
        end
      end
    end

    assign range_match[r] = (addr >= lo_r[r]) && (addr <= hi_r[r]);
  end

  assign in_range = |range_match;

endmodule

FILE: hdl/sactl_lookup.sv
// Tag compare, victim choice and row update for one set.
`timescale 1ns / 1ps
module sactl_lookup #(
  parameter int unsigned WAYS  = sactl_pkg::WAYS_DEF,
  parameter int unsigned TAG_W = 20,
  parameter int unsigned WAY_W = 2
) (
  input  logic                                kind,
  input  logic                                in_range,
  input  logic [TAG_W-1:0]                    tag,
  input  logic [WAYS-1:0]                     valid_row,
  input  logic [WAYS*TAG_W-1:0]               tag_row,
  input  logic [WAYS*sactl_pkg::STAMP_W-1:0]  stamp_row,
  input  logic [sactl_pkg::STAMP_W-1:0]       new_stamp,
  output sactl_pkg::lk_status_t               status,
  output logic [WAY_W-1:0]                    way,
  output logic [WAYS*TAG_W-1:0]               tag_row_nxt,
  output logic [WAYS*sactl_pkg::STAMP_W-1:0]  stamp_row_nxt
);
  import sactl_pkg::*;

  logic [WAYS-1:0]    match;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   free_way;
  logic [WAY_W-1:0]   lru_way;
  logic [WAY_W-1:0]   victim;
  logic [STAMP_W-1:0] least;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_row[w] && (tag_row[w*TAG_W +: TAG_W] == tag);
    end
  end

  // Walk downward so the lowest matching or free way wins.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid_row[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // Strict compare keeps the lowest way on equal stamps.
  always_comb begin
    least   = stamp_row[0 +: STAMP_W];
    lru_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (stamp_row[w*STAMP_W +: STAMP_W] < least) begin
        least   = stamp_row[w*STAMP_W +: STAMP_W];
        lru_way = WAY_W'(w);
      end
    end
  end

  assign victim = (&valid_row) ? lru_way : free_way;

  always_comb begin
    status.hit     = !in_range && (|match);
    status.fill    = !in_range && !(|match) && !kind;
    status.forward = in_range || kind;
    status.update  = status.hit || status.fill;
  end

  always_comb begin
    if (status.hit) begin
      way = hit_way;
    end else if (status.fill) begin
      way = victim;
    end else begin
      way = '0;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tag_row_nxt[w*TAG_W +: TAG_W] = (status.fill && way == WAY_W'(w)) ?
                                      tag : tag_row[w*TAG_W +: TAG_W];
      stamp_row_nxt[w*STAMP_W +: STAMP_W] = (status.update && way == WAY_W'(w)) ?
                                            new_stamp : stamp_row[w*STAMP_W +: STAMP_W];
    end
  end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the cache tag directory and LRU replacement unit.
`timescale 1ns / 1ps
module testbench;

  // Geometry of the default configuration.
  localparam int unsigned SETS       = sactl_pkg::SETS_DEF;
  localparam int unsigned WAYS       = sactl_pkg::WAYS_DEF;
  localparam int unsigned OFF_BITS   = $clog2(sactl_pkg::LINE_BYTES_DEF);
  localparam int unsigned SET_BITS   = $clog2(SETS);
  localparam int unsigned ADDR_W     = sactl_pkg::ADDR_BITS_DEF;
  localparam int unsigned TAG_BITS   = ADDR_W - SET_BITS - OFF_BITS;
  localparam int unsigned RANGES     = sactl_pkg::BYPASS_RANGES_DEF;
  localparam int unsigned IDX_W      = sactl_pkg::CFG_IDX_W;
  localparam int unsigned IDLE_PCT   = 29;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  // Cycles from acceptance to result, plus some slack.
  localparam int unsigned SETTLE_CYCLES = 6;

  // Register map: even index is the first address of a range, odd the last.
  localparam logic [IDX_W-1:0] REG_START_A  = 3'd0;
  localparam logic [IDX_W-1:0] REG_END_A    = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_B  = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_B    = 3'd3;
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd4;

  typedef enum logic {
    ACCESS_READ  = 1'b0,
    ACCESS_WRITE = 1'b1
  } access_kind_t;

  typedef struct {
    access_kind_t      kind;
    logic [ADDR_W-1:0] address;
  } access_t;

  // Result beat layout, lowest bit last.
  typedef struct packed {
    logic [OFF_BITS-1:0] byte_offset;
    logic [ADDR_W-1:0]   line_address;
    logic                forward;
    logic                fill_request;
    logic [1:0]          way;
    logic                hit;
    logic                bypass;
  } lookup_t;

  localparam int unsigned LOOKUP_W = $bits(lookup_t);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  set_assoc_cache_tag_lru_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // address
    .in_tuser   (in_tuser),    // kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // bypass, hit, way, fill_request, forward, line_address, byte_offset
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the directory, the use tick and the uncached ranges.
  logic                line_valid [SETS][WAYS];
  logic [TAG_BITS-1:0] line_tag   [SETS][WAYS];
  logic [31:0]         line_stamp [SETS][WAYS];
  logic [31:0]         tick;
  logic [ADDR_W-1:0]   range_first [RANGES];
  logic [ADDR_W-1:0]   range_last  [RANGES];

  access_t     access_queue[$];
  lookup_t     awaited_lookups[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  // While set, neither side inserts idle cycles.
  bit          steady = 1'b0;

  // Working set for the random part: a few tags per hot set force evictions.
  logic [TAG_BITS-1:0] tag_pool [6];
  logic [SET_BITS-1:0] hot_set;

  initial begin
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        line_valid[s][w] = 1'b0;
        line_tag[s][w]   = '0;
        line_stamp[s][w] = '0;
      end
    end
    tick = '0;
    for (int r = 0; r < RANGES; r++) begin
      range_first[r] = '1;
      range_last[r]  = '0;
    end
  end

  function automatic logic is_uncached(input logic [ADDR_W-1:0] addr);
    for (int r = 0; r < RANGES; r++) begin
      if (addr >= range_first[r] && addr <= range_last[r]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the result of one access and updates the shadow directory.
  function automatic lookup_t predict_lookup(input access_t acc);
    lookup_t             res;
    logic [SET_BITS-1:0] set_idx;
    logic [TAG_BITS-1:0] tag;
    logic                found;
    int unsigned         victim;
    res = '0;
    found = 1'b0;
    set_idx = acc.address[OFF_BITS +: SET_BITS];
    tag = acc.address[ADDR_W-1 -: TAG_BITS];
    res.line_address = {acc.address[ADDR_W-1:OFF_BITS], {OFF_BITS{1'b0}}};
    res.byte_offset = acc.address[OFF_BITS-1:0];
    if (is_uncached(acc.address)) begin
      // Uncached accesses pass straight through and leave the tick alone.
      res.bypass = 1'b1;
      res.forward = 1'b1;
      return res;
    end
    tick = tick + 32'd1;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
        found = 1'b1;
        res.way = 2'(w);
      end
    end
    if (found) begin
      res.hit = 1'b1;
      line_stamp[set_idx][res.way] = tick;
      res.forward = (acc.kind == ACCESS_WRITE);
    end else if (acc.kind == ACCESS_READ) begin
      // First invalid way, otherwise the oldest stamp, lowest way on a tie.
      victim = WAYS;
      for (int w = 0; w < WAYS; w++) begin
        if (victim == WAYS && !line_valid[set_idx][w]) victim = w;
      end
      if (victim == WAYS) begin
        victim = 0;
        for (int w = 1; w < WAYS; w++) begin
          if (line_stamp[set_idx][w] < line_stamp[set_idx][victim]) victim = w;
        end
      end
      res.way = 2'(victim);
      res.fill_request = 1'b1;
      line_valid[set_idx][victim] = 1'b1;
      line_tag[set_idx][victim] = tag;
      line_stamp[set_idx][victim] = tick;
    end else begin
      // Write miss: no allocation, only forwarded downstream.
      res.forward = 1'b1;
    end
    return res;
  endfunction

  // Sender: one beat per handshake, with random gaps between beats unless steady is set.
  always @(posedge clk) begin : sender
    access_t taken;
    logic    send;
    if (in_tvalid && in_tready) begin
      taken = access_queue.pop_front();
      awaited_lookups.insert(awaited_lookups.size(), predict_lookup(taken));
    end
    // A beat that is offered but not yet taken must stay up.
    if (in_tvalid && !in_tready) begin
      send = 1'b1;
    end else begin
      send = rst_n && access_queue.size() != 0 &&
             (steady || $urandom_range(99) >= IDLE_PCT);
    end
    in_tvalid <= send;
    if (send) begin
      in_tdata <= access_queue[0].address;
      in_tuser <= access_queue[0].kind;
    end
  end

  function automatic int unsigned field_diff(input string name, input logic [31:0] want,
                                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Receiver: every result beat is checked against the oldest prediction.
  always @(posedge clk) begin : receiver
    lookup_t seen;
    lookup_t want;
    if (out_tvalid && out_tready) begin
      seen = lookup_t'(out_tdata[LOOKUP_W-1:0]);
      if (awaited_lookups.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = awaited_lookups.pop_front();
        mismatch_count += field_diff("bypass", want.bypass, seen.bypass);
        mismatch_count += field_diff("hit", want.hit, seen.hit);
        mismatch_count += field_diff("way", want.way, seen.way);
        mismatch_count += field_diff("fill_request", want.fill_request, seen.fill_request);
        mismatch_count += field_diff("forward", want.forward, seen.forward);
        mismatch_count += field_diff("line_address", want.line_address, seen.line_address);
        mismatch_count += field_diff("byte_offset", want.byte_offset, seen.byte_offset);
      end
    end
    out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("set_assoc_cache_tag_lru_unit regression: fail");
      $finish;
    end
  end

  task automatic push_access(input access_kind_t kind, input logic [ADDR_W-1:0] addr);
    access_t acc;
    acc.kind = kind;
    acc.address = addr;
    access_queue.insert(access_queue.size(), acc);
  endtask

  function automatic logic [ADDR_W-1:0] line_in_set(input logic [TAG_BITS-1:0] tag,
                                                    input logic [SET_BITS-1:0] set_idx,
                                                    input logic [OFF_BITS-1:0] off);
    return {tag, set_idx, off};
  endfunction

  // Waits until nothing is queued or awaited, then lets the pipeline settle.
  task automatic wait_idle();
    while (access_queue.size() != 0 || awaited_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the unit is idle.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < 2 * RANGES) begin
      if (idx[0] == sactl_pkg::RANGE_BOUND_END) range_last[idx >> 1] = value;
      else range_first[idx >> 1] = value;
    end
  endtask

  task automatic refresh_working_set();
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(7))
        0: tag_pool[i] = '0;
        1: tag_pool[i] = '1;
        default: tag_pool[i] = TAG_BITS'($urandom());
      endcase
    end
    hot_set = SET_BITS'($urandom());
  endtask

  // Mostly accesses that contend for a few sets, some near range edges,
  // the rest anywhere in the address space.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned         roll;
    logic [SET_BITS-1:0] set_idx;
    logic [ADDR_W-1:0]   edge_addr;
    int unsigned         r;
    roll = $urandom_range(99);
    if (roll < 70) begin
      case ($urandom_range(3))
        0: set_idx = '0;
        1: set_idx = '1;
        2: set_idx = hot_set;
        default: set_idx = SET_BITS'($urandom());
      endcase
      return line_in_set(tag_pool[$urandom_range(5)], set_idx, OFF_BITS'($urandom()));
    end else if (roll < 82) begin
      r = $urandom_range(RANGES - 1);
      edge_addr = $urandom_range(1) ? range_first[r] : range_last[r];
      case ($urandom_range(2))
        0: return edge_addr - 1;
        1: return edge_addr;
        default: return edge_addr + 1;
      endcase
    end
    return $urandom();
  endfunction

  // Random accesses in chunks; every third chunk the sender holds off
  // until all results are back.
  task automatic run_random(input int unsigned count);
    int unsigned chunk;
    chunk = 0;
    refresh_working_set();
    for (int unsigned i = 0; i < count; i++) begin
      push_access($urandom_range(99) < 35 ? ACCESS_WRITE : ACCESS_READ, pick_address());
      if ((i + 1) % 40 == 0) begin
        while (access_queue.size() != 0) @(posedge clk);
        chunk++;
        if (chunk % 3 == 0) wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: nothing is uncached. First a stretch with no idling.
    steady = 1'b1;
    push_access(ACCESS_READ,  32'h0000_0000);   // cold miss fills way 0
    push_access(ACCESS_READ,  32'h0000_003F);   // same line, read hit
    push_access(ACCESS_WRITE, 32'h0000_0000);   // write hit is forwarded
    push_access(ACCESS_WRITE, 32'hFFFF_FFFF);   // write miss does not allocate
    push_access(ACCESS_READ,  32'hFFFF_FFFF);   // read miss in the top set
    push_access(ACCESS_WRITE, 32'hFFFF_FFC0);   // write hit on that line
    // Fill all ways of one set, touch one, then force evictions.
    for (int t = 1; t <= 4; t++) begin
      push_access(ACCESS_READ, line_in_set(TAG_BITS'(t), 6'd5, 6'(t)));
    end
    push_access(ACCESS_READ,  line_in_set(20'd2, 6'd5, 6'd0));   // hit refreshes way 1
    push_access(ACCESS_READ,  line_in_set(20'd5, 6'd5, 6'd0));   // evicts the oldest
    push_access(ACCESS_READ,  line_in_set(20'd1, 6'd5, 6'd0));   // evicted tag misses
    push_access(ACCESS_WRITE, line_in_set(20'd9, 6'd5, 6'd0));   // write miss, no fill
    push_access(ACCESS_READ,  line_in_set(20'd9, 6'd5, 6'd63));  // so this misses
    wait_idle();
    run_random(200);
    steady = 1'b0;

    // One block range and one single-address range, probed at their edges.
    write_reg(REG_START_A, 32'h0000_1000);
    write_reg(REG_END_A,   32'h0000_1FFF);
    write_reg(REG_START_B, 32'h8000_0040);
    write_reg(REG_END_B,   32'h8000_0040);
    push_access(ACCESS_READ,  32'h0000_0FFF);
    push_access(ACCESS_READ,  32'h0000_1000);
    push_access(ACCESS_WRITE, 32'h0000_1FFF);
    push_access(ACCESS_READ,  32'h0000_2000);
    push_access(ACCESS_WRITE, 32'h8000_0040);
    push_access(ACCESS_READ,  32'h8000_003F);
    push_access(ACCESS_READ,  32'h8000_0041);
    wait_idle();
    run_random(200);

    // Whole address space uncached; range B disabled with start above end.
    write_reg(REG_START_A, 32'h0000_0000);
    write_reg(REG_END_A,   32'hFFFF_FFFF);
    write_reg(REG_START_B, 32'hFFFF_FF00);
    write_reg(REG_END_B,   32'h0000_00FF);
    run_random(60);

    // Range A disabled, range B somewhere in the upper half. Writes to
    // unmapped indexes must leave the ranges as they are.
    write_reg(REG_START_A, 32'hFFFF_FFFF);
    write_reg(REG_END_A,   32'hFFFF_FFFE);
    begin
      logic [ADDR_W-1:0] b_first;
      b_first = 32'h8000_0000 + $urandom_range(32'h3FFF_FFFF);
      write_reg(REG_START_B, b_first);
      write_reg(REG_END_B, b_first + $urandom_range(32'h000F_FFFF));
    end
    for (int i = 0; i < 4; i++) begin
      write_reg(REG_UNMAPPED + IDX_W'(i), $urandom());
    end
    run_random(200);

    // Single-address ranges at both ends of the address space.
    write_reg(REG_START_A, 32'h0000_0000);
    write_reg(REG_END_A,   32'h0000_0000);
    write_reg(REG_START_B, 32'hFFFF_FFFF);
    write_reg(REG_END_B,   32'hFFFF_FFFF);
    run_random(190);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("set_assoc_cache_tag_lru_unit regression: pass");
    end else begin
      $display("set_assoc_cache_tag_lru_unit regression: fail");
    end
    $finish;
  end

endmodule
